// ===== rtl/cfpa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfpa_pkg
// Shared types and constants of the complex fixed-point arithmetic core.
// ----------------------------------------------------------------------------
package cfpa_pkg;

  localparam int unsigned CFPA_WORD_BITS = 32;
  localparam int unsigned CFPA_FRAC_BITS = 16;
  localparam int unsigned EPS_BITS       = 31;
  localparam int unsigned OP_BITS        = 4;

  localparam logic [EPS_BITS-1:0] EPS_RESET = EPS_BITS'(1);

  typedef enum logic [OP_BITS-1:0] {
    OP_ADD  = 4'd0,
    OP_SUB  = 4'd1,
    OP_MUL  = 4'd2,
    OP_SMUL = 4'd3,
    OP_DIV  = 4'd4,
    OP_SDIV = 4'd5,
    OP_CONJ = 4'd6,
    OP_MOD  = 4'd7,
    OP_CMP  = 4'd8,
    OP_SCMP = 4'd9
  } op_t;

  // How the back half of the pipe treats an item
  typedef enum logic [2:0] {
    K_ZERO,
    K_ADD,
    K_MUL,
    K_DIV,
    K_SQRT,
    K_CMP
  } kind_t;

  typedef struct packed {
    kind_t kind;
    logic  neg_re;
    logic  neg_im;
    logic  den_neg;
    logic  is_div4;
    logic  is_eq;
    logic  is_gt;
    logic  is_ge;
    logic  div_err;
  } ctrl_t;

  // Result flags, is_equal in the lowest bit
  typedef struct packed {
    logic saturated;
    logic div_error;
    logic is_greater_equal;
    logic is_greater;
    logic is_equal;
  } flags_t;

endpackage

// ===== rtl/cfpa_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfpa_front
// Two stages: operand products, then per-opcode sums and divisor selection.
// ----------------------------------------------------------------------------
module cfpa_front #(
  parameter int WORD_BITS = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              up_valid,
  output logic                              up_ready,
  input  logic [cfpa_pkg::OP_BITS-1:0]      op_i,
  input  logic signed [WORD_BITS-1:0]       a_re_i,
  input  logic signed [WORD_BITS-1:0]       a_im_i,
  input  logic signed [WORD_BITS-1:0]       b_re_i,
  input  logic signed [WORD_BITS-1:0]       b_im_i,
  input  logic [cfpa_pkg::EPS_BITS-1:0]     eps_i,
  output logic                              dn_valid,
  input  logic                              dn_ready,
  output cfpa_pkg::ctrl_t                   ctrl_o,
  output logic signed [2*WORD_BITS:0]       num_re_o,
  output logic signed [2*WORD_BITS:0]       num_im_o,
  output logic [2*WORD_BITS-1:0]            den_o
);
  import cfpa_pkg::*;

  localparam int W    = WORD_BITS;
  localparam int P    = 2 * WORD_BITS;
  localparam int SW   = P + 1;
  localparam int CMPW = (W > EPS_BITS) ? W : EPS_BITS;

  logic                 va_r, vb_r, rdy_a, rdy_b;
  logic [OP_BITS-1:0]   op_r;
  logic signed [W-1:0]  a_r, b_r, c_r, d_r;
  logic signed [P-1:0]  ac_r, bd_r, ad_r, bc_r, aa_r, bb_r, cc_r, dd_r;

  ctrl_t                ctrl_nxt, ctrl_r;
  logic signed [SW-1:0] num_re_nxt, num_im_nxt, num_re_r, num_im_r;
  logic [P-1:0]         den_nxt, den_r;
  logic [W-1:0]         mag_b, mag_c;

  assign rdy_b    = !vb_r || dn_ready;
  assign rdy_a    = !va_r || rdy_b;
  assign up_ready = rdy_a;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else begin
      if (rdy_a) va_r <= up_valid;
      if (rdy_b) vb_r <= va_r;
    end
  end

  // Stage A: all products
  always_ff @(posedge clk) begin
    if (rdy_a) begin
      op_r <= op_i;
      a_r  <= a_re_i;
      b_r  <= a_im_i;
      c_r  <= b_re_i;
      d_r  <= b_im_i;
      ac_r <= a_re_i * b_re_i;
      bd_r <= a_im_i * b_im_i;
      ad_r <= a_re_i * b_im_i;
      bc_r <= a_im_i * b_re_i;
      aa_r <= a_re_i * a_re_i;
      bb_r <= a_im_i * a_im_i;
      cc_r <= b_re_i * b_re_i;
      dd_r <= b_im_i * b_im_i;
    end
  end

  assign mag_b = b_r[W-1] ? W'(-b_r) : W'(b_r);
  assign mag_c = c_r[W-1] ? W'(-c_r) : W'(c_r);

  // Stage B: per-opcode numerators and divisor
  always_comb begin
    ctrl_nxt   = '0;
    ctrl_nxt.kind = K_ZERO;
    num_re_nxt = '0;
    num_im_nxt = '0;
    den_nxt    = '0;
    case (op_t'(op_r))
      OP_ADD: begin
        ctrl_nxt.kind = K_ADD;
        num_re_nxt = SW'(a_r) + SW'(c_r);
        num_im_nxt = SW'(b_r) + SW'(d_r);
      end
      OP_SUB: begin
        ctrl_nxt.kind = K_ADD;
        num_re_nxt = SW'(a_r) - SW'(c_r);
        num_im_nxt = SW'(b_r) - SW'(d_r);
      end
      OP_MUL: begin
        ctrl_nxt.kind = K_MUL;
        num_re_nxt = SW'(ac_r) - SW'(bd_r);
        num_im_nxt = SW'(ad_r) + SW'(bc_r);
      end
      OP_SMUL: begin
        ctrl_nxt.kind = K_MUL;
        num_re_nxt = SW'(ac_r);
        num_im_nxt = SW'(bc_r);
      end
      OP_DIV: begin
        ctrl_nxt.kind    = K_DIV;
        ctrl_nxt.is_div4 = 1'b1;
        num_re_nxt = SW'(ac_r) + SW'(bd_r);
        num_im_nxt = SW'(bc_r) - SW'(ad_r);
        den_nxt    = $unsigned(cc_r) + $unsigned(dd_r);
      end
      OP_SDIV: begin
        if (c_r == '0) begin
          ctrl_nxt.div_err = 1'b1;
        end else begin
          ctrl_nxt.kind    = K_DIV;
          ctrl_nxt.den_neg = c_r[W-1];
          num_re_nxt = SW'(a_r);
          num_im_nxt = SW'(b_r);
          den_nxt    = P'(mag_c);
        end
      end
      OP_CONJ: begin
        ctrl_nxt.kind = K_ADD;
        num_re_nxt = SW'(a_r);
        // keep a tiny imaginary part as it is
        num_im_nxt = (CMPW'(mag_b) < CMPW'(eps_i)) ? SW'(b_r) : -SW'(b_r);
      end
      OP_MOD: begin
        ctrl_nxt.kind = K_SQRT;
        num_re_nxt = SW'(aa_r) + SW'(bb_r);
      end
      OP_CMP: begin
        ctrl_nxt.kind  = K_CMP;
        ctrl_nxt.is_eq = (a_r == c_r) && (b_r == d_r);
        num_re_nxt = SW'(aa_r) + SW'(bb_r);
        den_nxt    = $unsigned(cc_r) + $unsigned(dd_r);
      end
      OP_SCMP: begin
        ctrl_nxt.kind    = K_CMP;
        ctrl_nxt.is_eq   = (a_r == c_r) && (b_r == '0);
        ctrl_nxt.den_neg = c_r[W-1];
        num_re_nxt = SW'(aa_r) + SW'(bb_r);
        den_nxt    = $unsigned(cc_r);
      end
      default: begin
        ctrl_nxt.kind = K_ZERO;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rdy_b) begin
      ctrl_r   <= ctrl_nxt;
      num_re_r <= num_re_nxt;
      num_im_r <= num_im_nxt;
      den_r    <= den_nxt;
    end
  end

  assign dn_valid = vb_r;
  assign ctrl_o   = ctrl_r;
  assign num_re_o = num_re_r;
  assign num_im_o = num_im_r;
  assign den_o    = den_r;

endmodule

// ===== rtl/cfpa_prep.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfpa_prep
// Two stages: sign and magnitude, compares and divisor check; then the
// rounded product, scaled dividend for divide steps, or the plain magnitude.
// ----------------------------------------------------------------------------
module cfpa_prep #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              up_valid,
  output logic                              up_ready,
  input  cfpa_pkg::ctrl_t                   ctrl_i,
  input  logic signed [2*WORD_BITS:0]       num_re_i,
  input  logic signed [2*WORD_BITS:0]       num_im_i,
  input  logic [2*WORD_BITS-1:0]            den_i,
  input  logic [cfpa_pkg::EPS_BITS-1:0]     eps_i,
  output logic                              dn_valid,
  input  logic                              dn_ready,
  output cfpa_pkg::ctrl_t                   ctrl_o,
  output logic [2*WORD_BITS+FRAC_BITS-1:0]  r_re_o,
  output logic [2*WORD_BITS+FRAC_BITS-1:0]  r_im_o,
  output logic [2*WORD_BITS-1:0]            den_o
);
  import cfpa_pkg::*;

  localparam int P  = 2 * WORD_BITS;
  localparam int SW = P + 1;
  localparam int NW = P + FRAC_BITS;
  localparam int EW = P + EPS_BITS + FRAC_BITS;

  logic          vc_r, vd_r, rdy_c, rdy_d;
  ctrl_t         ctrl_c_nxt, ctrl_c_r, ctrl_d_r;
  logic [P-1:0]  m_re_nxt, m_im_nxt, m_re_r, m_im_r, den_c_r, den_d_r;
  logic [NW-1:0] r_re_nxt, r_im_nxt, r_re_r, r_im_r;
  logic [P:0]    rnd_re, rnd_im;

  assign rdy_d    = !vd_r || dn_ready;
  assign rdy_c    = !vc_r || rdy_d;
  assign up_ready = rdy_c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= 1'b0;
      vd_r <= 1'b0;
    end else begin
      if (rdy_c) vc_r <= up_valid;
      if (rdy_d) vd_r <= vc_r;
    end
  end

  // Stage C
  always_comb begin
    ctrl_c_nxt        = ctrl_i;
    ctrl_c_nxt.neg_re = num_re_i[SW-1];
    ctrl_c_nxt.neg_im = num_im_i[SW-1];
    m_re_nxt = num_re_i[SW-1] ? P'(-num_re_i) : P'(num_re_i);
    m_im_nxt = num_im_i[SW-1] ? P'(-num_im_i) : P'(num_im_i);
    case (ctrl_i.kind)
      K_DIV: begin
        ctrl_c_nxt.neg_re = num_re_i[SW-1] ^ ctrl_i.den_neg;
        ctrl_c_nxt.neg_im = num_im_i[SW-1] ^ ctrl_i.den_neg;
        if (ctrl_i.is_div4 &&
            ((den_i == '0) || (EW'(den_i) < (EW'(eps_i) << FRAC_BITS)))) begin
          ctrl_c_nxt.kind    = K_ZERO;
          ctrl_c_nxt.div_err = 1'b1;
        end
      end
      K_CMP: begin
        // a negative scalar loses to any modulus
        ctrl_c_nxt.is_gt = ctrl_i.den_neg || (num_re_i[P-1:0] > den_i);
        ctrl_c_nxt.is_ge = ctrl_i.den_neg || (num_re_i[P-1:0] >= den_i);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rdy_c) begin
      ctrl_c_r <= ctrl_c_nxt;
      m_re_r   <= m_re_nxt;
      m_im_r   <= m_im_nxt;
      den_c_r  <= den_i;
    end
  end

  // Stage D
  assign rnd_re = (P+1)'(m_re_r) + ((P+1)'(1) << (FRAC_BITS - 1));
  assign rnd_im = (P+1)'(m_im_r) + ((P+1)'(1) << (FRAC_BITS - 1));

  always_comb begin
    r_re_nxt = '0;
    r_im_nxt = '0;
    case (ctrl_c_r.kind)
      K_DIV: begin
        r_re_nxt = (NW'(m_re_r) << FRAC_BITS) + NW'(den_c_r >> 1);
        r_im_nxt = (NW'(m_im_r) << FRAC_BITS) + NW'(den_c_r >> 1);
      end
      K_MUL: begin
        r_re_nxt = NW'(rnd_re >> FRAC_BITS);
        r_im_nxt = NW'(rnd_im >> FRAC_BITS);
      end
      K_ADD: begin
        r_re_nxt = NW'(m_re_r);
        r_im_nxt = NW'(m_im_r);
      end
      K_SQRT: begin
        r_re_nxt = NW'(m_re_r);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rdy_d) begin
      ctrl_d_r <= ctrl_c_r;
      r_re_r   <= r_re_nxt;
      r_im_r   <= r_im_nxt;
      den_d_r  <= den_c_r;
    end
  end

  assign dn_valid = vd_r;
  assign ctrl_o   = ctrl_d_r;
  assign r_re_o   = r_re_r;
  assign r_im_o   = r_im_r;
  assign den_o    = den_d_r;

endmodule

// ===== rtl/cfpa_iter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfpa_iter
// One registered step: a quotient bit for both divide lanes, or one root
// bit of the square root.
// ----------------------------------------------------------------------------
module cfpa_iter #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 16,
  parameter int STEP      = 0
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              up_valid,
  output logic                              up_ready,
  input  cfpa_pkg::ctrl_t                   ctrl_i,
  input  logic [2*WORD_BITS+FRAC_BITS-1:0]  r_re_i,
  input  logic [2*WORD_BITS+FRAC_BITS-1:0]  r_im_i,
  input  logic [WORD_BITS+1:0]              q_re_i,
  input  logic [WORD_BITS+1:0]              q_im_i,
  input  logic [2*WORD_BITS-1:0]            den_i,
  output logic                              dn_valid,
  input  logic                              dn_ready,
  output cfpa_pkg::ctrl_t                   ctrl_o,
  output logic [2*WORD_BITS+FRAC_BITS-1:0]  r_re_o,
  output logic [2*WORD_BITS+FRAC_BITS-1:0]  r_im_o,
  output logic [WORD_BITS+1:0]              q_re_o,
  output logic [WORD_BITS+1:0]              q_im_o,
  output logic [2*WORD_BITS-1:0]            den_o
);
  import cfpa_pkg::*;

  localparam int W  = WORD_BITS;
  localparam int NW = 2 * WORD_BITS + FRAC_BITS;
  localparam int CW = 3 * WORD_BITS + 2;
  localparam int QB = W + 1 - STEP;                    // quotient bit
  localparam int RB = (STEP < W) ? (W - 1 - STEP) : 0; // root bit

  logic          v_r, rdy;
  ctrl_t         ctrl_r;
  logic [NW-1:0] r_re_nxt, r_im_nxt, r_re_r, r_im_r, trial;
  logic [W+1:0]  q_re_nxt, q_im_nxt, q_re_r, q_im_r;
  logic [2*W-1:0] den_r;
  logic [CW-1:0] den_sh;

  assign rdy      = !v_r || dn_ready;
  assign up_ready = rdy;

  assign den_sh = CW'(den_i) << QB;
  assign trial  = (NW'(q_re_i[W-1:0]) << (RB + 1)) + (NW'(1) << (2 * RB));

  always_comb begin
    r_re_nxt = r_re_i;
    r_im_nxt = r_im_i;
    q_re_nxt = q_re_i;
    q_im_nxt = q_im_i;
    case (ctrl_i.kind)
      K_DIV: begin
        // the top step only flags a quotient that is out of range
        if (CW'(r_re_i) >= den_sh) begin
          r_re_nxt     = r_re_i - NW'(den_sh);
          q_re_nxt[QB] = 1'b1;
        end
        if (CW'(r_im_i) >= den_sh) begin
          r_im_nxt     = r_im_i - NW'(den_sh);
          q_im_nxt[QB] = 1'b1;
        end
      end
      K_SQRT: begin
        if ((STEP < W) && (r_re_i >= trial)) begin
          r_re_nxt     = r_re_i - trial;
          q_re_nxt[RB] = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (rdy) begin
      v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy) begin
      ctrl_r <= ctrl_i;
      r_re_r <= r_re_nxt;
      r_im_r <= r_im_nxt;
      q_re_r <= q_re_nxt;
      q_im_r <= q_im_nxt;
      den_r  <= den_i;
    end
  end

  assign dn_valid = v_r;
  assign ctrl_o   = ctrl_r;
  assign r_re_o   = r_re_r;
  assign r_im_o   = r_im_r;
  assign q_re_o   = q_re_r;
  assign q_im_o   = q_im_r;
  assign den_o    = den_r;

endmodule

// ===== rtl/cfpa_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfpa_back
// Output register: root rounding, saturation and flag assembly.
// ----------------------------------------------------------------------------
module cfpa_back #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              up_valid,
  output logic                              up_ready,
  input  cfpa_pkg::ctrl_t                   ctrl_i,
  input  logic [2*WORD_BITS+FRAC_BITS-1:0]  r_re_i,
  input  logic [2*WORD_BITS+FRAC_BITS-1:0]  r_im_i,
  input  logic [WORD_BITS+1:0]              q_re_i,
  input  logic [WORD_BITS+1:0]              q_im_i,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [WORD_BITS-1:0]       res_re_o,
  output logic signed [WORD_BITS-1:0]       res_im_o,
  output cfpa_pkg::flags_t                  flags_o
);
  import cfpa_pkg::*;

  localparam int W  = WORD_BITS;
  localparam int NW = 2 * WORD_BITS + FRAC_BITS;

  logic          v_r, rdy, use_re, use_im;
  logic [NW-1:0] mag_re, mag_im;
  logic [W:0]    cl_re, cl_im;
  logic [W-1:0]  res_re_r, res_im_r;
  flags_t        flags_nxt, flags_r;

  function automatic logic [W:0] clamp(input logic neg, input logic [NW-1:0] mag);
    logic [NW-1:0] lim;
    logic [W-1:0]  val;
    logic          s;
    lim = (NW'(1) << (W - 1)) - (neg ? NW'(0) : NW'(1));
    s   = mag > lim;
    val = s ? lim[W-1:0] : mag[W-1:0];
    return {s, (neg ? (~val + 1'b1) : val)};
  endfunction

  assign rdy      = !v_r || out_ready;
  assign up_ready = rdy;

  always_comb begin
    mag_re = '0;
    mag_im = '0;
    use_re = 1'b0;
    use_im = 1'b0;
    case (ctrl_i.kind)
      K_ADD, K_MUL: begin
        mag_re = r_re_i;
        mag_im = r_im_i;
        use_re = 1'b1;
        use_im = 1'b1;
      end
      K_DIV: begin
        mag_re = NW'(q_re_i);
        mag_im = NW'(q_im_i);
        use_re = 1'b1;
        use_im = 1'b1;
      end
      K_SQRT: begin
        // round up when the remainder passes the root
        mag_re = NW'(q_re_i[W-1:0]) + NW'(r_re_i > NW'(q_re_i[W-1:0]));
        use_re = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign cl_re = clamp(ctrl_i.neg_re && use_re, mag_re);
  assign cl_im = clamp(ctrl_i.neg_im && use_im, mag_im);

  always_comb begin
    flags_nxt                  = '0;
    flags_nxt.is_equal         = ctrl_i.is_eq;
    flags_nxt.is_greater       = ctrl_i.is_gt;
    flags_nxt.is_greater_equal = ctrl_i.is_ge;
    flags_nxt.div_error        = ctrl_i.div_err;
    flags_nxt.saturated        = (use_re && cl_re[W]) || (use_im && cl_im[W]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (rdy) begin
      v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy) begin
      res_re_r <= use_re ? cl_re[W-1:0] : '0;
      res_im_r <= use_im ? cl_im[W-1:0] : '0;
      flags_r  <= flags_nxt;
    end
  end

  assign out_valid = v_r;
  assign res_re_o  = $signed(res_re_r);
  assign res_im_o  = $signed(res_im_r);
  assign flags_o   = flags_r;

endmodule

// ===== rtl/complex_fixed_point_alu_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// complex_fixed_point_alu_core
// Pipelined complex fixed-point arithmetic unit with saturating results.
// ----------------------------------------------------------------------------
// The core takes one item per clock unless the output stalls, and returns one
// result item for each, in order, through these stages: two stages form
// the operand products and sums, two more form magnitudes, compares and the
// scaled dividend, WORD_BITS+2 step stages run the restoring divide (both
// parts in parallel) or the bit-per-stage square root, and one output
// register rounds, saturates and holds the result. Every stage has its own
// valid bit; a stage loads whenever it is empty or the next one moves, so a
// stall at the output fills the bubbles before it pushes back on in_tready.
// Operands and results are signed fixed point with FRAC_BITS fraction bits.
// The divide threshold register resets to 1 and should be written only when
// no item is in flight.
module complex_fixed_point_alu_core #(
  parameter int WORD_BITS = cfpa_pkg::CFPA_WORD_BITS,
  parameter int FRAC_BITS = cfpa_pkg::CFPA_FRAC_BITS
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // configuration: div_epsilon
  input  logic                                 cfg_wr_en,
  input  logic [cfpa_pkg::EPS_BITS-1:0]        cfg_wr_data,
  // input items
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // a_re, a_im, b_re, b_im from the lowest bit up
  input  logic [((4*WORD_BITS+7)/8)*8-1:0]     in_tdata,
  // op
  input  logic [cfpa_pkg::OP_BITS-1:0]         in_tuser,
  // result items
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // res_re, res_im from the lowest bit up
  output logic [((2*WORD_BITS+7)/8)*8-1:0]     out_tdata,
  // is_equal, is_greater, is_greater_equal, div_error, saturated
  output logic [4:0]                           out_tuser
);
  import cfpa_pkg::*;

  localparam int W      = WORD_BITS;
  localparam int P      = 2 * WORD_BITS;
  localparam int NW     = P + FRAC_BITS;
  localparam int NSTEP  = WORD_BITS + 2;
  localparam int OUT_DW = ((2 * WORD_BITS + 7) / 8) * 8;

  logic [EPS_BITS-1:0] eps_r;

  // front -> prep
  logic               f_valid, f_ready;
  ctrl_t              f_ctrl;
  logic signed [P:0]  f_num_re, f_num_im;
  logic [P-1:0]       f_den;

  // step chain, index k feeds step k
  logic               s_valid [0:NSTEP];
  logic               s_ready [0:NSTEP];
  ctrl_t              s_ctrl  [0:NSTEP];
  logic [NW-1:0]      s_r_re  [0:NSTEP];
  logic [NW-1:0]      s_r_im  [0:NSTEP];
  logic [W+1:0]       s_q_re  [0:NSTEP];
  logic [W+1:0]       s_q_im  [0:NSTEP];
  logic [P-1:0]       s_den   [0:NSTEP];

  logic signed [W-1:0] res_re, res_im;
  flags_t              flags;

  // Hold the threshold; writes must land only while idle (not enforced here)
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eps_r <= EPS_RESET;
    end else if (cfg_wr_en) begin
      eps_r <= cfg_wr_data;
    end
  end

  cfpa_front #(
    .WORD_BITS (WORD_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_tvalid),
    .up_ready (in_tready),
    .op_i     (in_tuser),
    .a_re_i   ($signed(in_tdata[W-1:0])),
    .a_im_i   ($signed(in_tdata[2*W-1:W])),
    .b_re_i   ($signed(in_tdata[3*W-1:2*W])),
    .b_im_i   ($signed(in_tdata[4*W-1:3*W])),
    .eps_i    (eps_r),
    .dn_valid (f_valid),
    .dn_ready (f_ready),
    .ctrl_o   (f_ctrl),
    .num_re_o (f_num_re),
    .num_im_o (f_num_im),
    .den_o    (f_den)
  );

  cfpa_prep #(
    .WORD_BITS (WORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_prep (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (f_valid),
    .up_ready (f_ready),
    .ctrl_i   (f_ctrl),
    .num_re_i (f_num_re),
    .num_im_i (f_num_im),
    .den_i    (f_den),
    .eps_i    (eps_r),
    .dn_valid (s_valid[0]),
    .dn_ready (s_ready[0]),
    .ctrl_o   (s_ctrl[0]),
    .r_re_o   (s_r_re[0]),
    .r_im_o   (s_r_im[0]),
    .den_o    (s_den[0])
  );

  // Start quotient and root at zero
  assign s_q_re[0] = '0;
  assign s_q_im[0] = '0;

  for (genvar k = 0; k < NSTEP; k++) begin : g_step
    cfpa_iter #(
      .WORD_BITS (WORD_BITS),
      .FRAC_BITS (FRAC_BITS),
      .STEP      (k)
    ) u_iter (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (s_valid[k]),
      .up_ready (s_ready[k]),
      .ctrl_i   (s_ctrl[k]),
      .r_re_i   (s_r_re[k]),
      .r_im_i   (s_r_im[k]),
      .q_re_i   (s_q_re[k]),
      .q_im_i   (s_q_im[k]),
      .den_i    (s_den[k]),
      .dn_valid (s_valid[k+1]),
      .dn_ready (s_ready[k+1]),
      .ctrl_o   (s_ctrl[k+1]),
      .r_re_o   (s_r_re[k+1]),
      .r_im_o   (s_r_im[k+1]),
      .q_re_o   (s_q_re[k+1]),
      .q_im_o   (s_q_im[k+1]),
      .den_o    (s_den[k+1])
    );
  end

  cfpa_back #(
    .WORD_BITS (WORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_valid  (s_valid[NSTEP]),
    .up_ready  (s_ready[NSTEP]),
    .ctrl_i    (s_ctrl[NSTEP]),
    .r_re_i    (s_r_re[NSTEP]),
    .r_im_i    (s_r_im[NSTEP]),
    .q_re_i    (s_q_re[NSTEP]),
    .q_im_i    (s_q_im[NSTEP]),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .res_re_o  (res_re),
    .res_im_o  (res_im),
    .flags_o   (flags)
  );

  // Pack the result, zero fill up to whole bytes
  assign out_tdata = OUT_DW'({res_im, res_re});
  assign out_tuser = flags;

endmodule

// ===== verif/tb_complex_fixed_point_alu_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_complex_fixed_point_alu_core
// Self-checking bench for the complex fixed-point arithmetic core: a
// bit-exact predictor computes each result from the accepted input item,
// and a scoreboard compares results in order while both stream sides idle
// and stall at random across several threshold settings.
// ----------------------------------------------------------------------------
module tb_complex_fixed_point_alu_core;
  import cfpa_pkg::*;

  typedef logic signed [127:0] s128_t;
  typedef logic [127:0]        u128_t;

  typedef struct {
    logic [31:0] re;
    logic [31:0] im;
    flags_t      fl;
  } alu_result_t;

  localparam s128_t MAXV = s128_t'(64'sd2147483647);
  localparam s128_t MINV = -s128_t'(64'sd2147483648);
  localparam int    PHASE_ITEMS = 190;
  localparam int    DRAIN_CYCLES = 60;

  // Scoreboard: predicts each accepted item and holds results in order
  class alu_scoreboard;
    alu_result_t pending[$];
    logic [30:0] eps = EPS_RESET;
    int          fails = 0;

    function u128_t mag(s128_t v);
      return v < 0 ? u128_t'(-v) : u128_t'(v);
    endfunction

    function logic [31:0] clamp(s128_t v, inout bit sat);
      if (v > MAXV) begin
        sat = 1;
        return MAXV[31:0];
      end
      if (v < MINV) begin
        sat = 1;
        return MINV[31:0];
      end
      return v[31:0];
    endfunction

    // product rounding: shift with half step added, ties away from zero
    function s128_t rnd(s128_t v);
      s128_t m;
      m = s128_t'((mag(v) + (u128_t'(1) << (CFPA_FRAC_BITS - 1))) >> CFPA_FRAC_BITS);
      return v < 0 ? -m : m;
    endfunction

    function s128_t qdiv(s128_t num, u128_t den, bit den_neg);
      s128_t m;
      m = s128_t'(((mag(num) << CFPA_FRAC_BITS) + (den >> 1)) / den);
      return ((num < 0) != den_neg) ? -m : m;
    endfunction

    function u128_t isqrt_round(u128_t n);
      u128_t res, bitv;
      res = 0;
      bitv = u128_t'(1) << 126;
      while (bitv > n) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (n >= res + bitv) begin
          n = n - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
        bitv = bitv >> 2;
      end
      return (n > res) ? res + 1 : res;
    endfunction

    function void note(logic [3:0] op, logic [127:0] data);
      s128_t ar, ai, br, bi, den;
      alu_result_t r;
      bit sat;
      ar = s128_t'($signed(data[31:0]));
      ai = s128_t'($signed(data[63:32]));
      br = s128_t'($signed(data[95:64]));
      bi = s128_t'($signed(data[127:96]));
      r = '{re: '0, im: '0, fl: '0};
      sat = 0;
      case (op)
        OP_ADD: begin
          r.re = clamp(ar + br, sat);
          r.im = clamp(ai + bi, sat);
        end
        OP_SUB: begin
          r.re = clamp(ar - br, sat);
          r.im = clamp(ai - bi, sat);
        end
        OP_MUL: begin
          r.re = clamp(rnd(ar * br - ai * bi), sat);
          r.im = clamp(rnd(ar * bi + ai * br), sat);
        end
        OP_SMUL: begin
          r.re = clamp(rnd(ar * br), sat);
          r.im = clamp(rnd(ai * br), sat);
        end
        OP_DIV: begin
          den = br * br + bi * bi;
          if (den == 0 || u128_t'(den) < (u128_t'(eps) << CFPA_FRAC_BITS)) begin
            r.fl.div_error = 1;
          end else begin
            r.re = clamp(qdiv(ar * br + ai * bi, u128_t'(den), 0), sat);
            r.im = clamp(qdiv(ai * br - ar * bi, u128_t'(den), 0), sat);
          end
        end
        OP_SDIV: begin
          if (br == 0) begin
            r.fl.div_error = 1;
          end else begin
            r.re = clamp(qdiv(ar, mag(br), br < 0), sat);
            r.im = clamp(qdiv(ai, mag(br), br < 0), sat);
          end
        end
        OP_CONJ: begin
          r.re = ar[31:0];
          if (mag(ai) < u128_t'(eps)) r.im = ai[31:0];
          else r.im = clamp(-ai, sat);
        end
        OP_MOD: begin
          r.re = clamp(s128_t'(isqrt_round(u128_t'(ar * ar + ai * ai))), sat);
        end
        OP_CMP: begin
          r.fl.is_equal = (ar == br) && (ai == bi);
          r.fl.is_greater = (ar * ar + ai * ai) > (br * br + bi * bi);
          r.fl.is_greater_equal = (ar * ar + ai * ai) >= (br * br + bi * bi);
        end
        OP_SCMP: begin
          r.fl.is_equal = (ar == br) && (ai == 0);
          if (br < 0) begin
            r.fl.is_greater = 1;
            r.fl.is_greater_equal = 1;
          end else begin
            r.fl.is_greater = (ar * ar + ai * ai) > br * br;
            r.fl.is_greater_equal = (ar * ar + ai * ai) >= br * br;
          end
        end
        default: ;
      endcase
      r.fl.saturated = sat;
      pending.push_back(r);
    endfunction

    function void check(logic [63:0] data, logic [4:0] user);
      alu_result_t e;
      flags_t got;
      if (pending.size() == 0) begin
        $error("result item with nothing pending: tdata=%h tuser=%b", data, user);
        fails++;
        return;
      end
      e = pending.pop_front();
      got = user;
      if (data[31:0] !== e.re) begin
        $error("res_re: expected %h, got %h", e.re, data[31:0]);
        fails++;
      end
      if (data[63:32] !== e.im) begin
        $error("res_im: expected %h, got %h", e.im, data[63:32]);
        fails++;
      end
      if (got.is_equal !== e.fl.is_equal) begin
        $error("is_equal: expected %b, got %b", e.fl.is_equal, got.is_equal);
        fails++;
      end
      if (got.is_greater !== e.fl.is_greater) begin
        $error("is_greater: expected %b, got %b", e.fl.is_greater, got.is_greater);
        fails++;
      end
      if (got.is_greater_equal !== e.fl.is_greater_equal) begin
        $error("is_greater_equal: expected %b, got %b",
               e.fl.is_greater_equal, got.is_greater_equal);
        fails++;
      end
      if (got.div_error !== e.fl.div_error) begin
        $error("div_error: expected %b, got %b", e.fl.div_error, got.div_error);
        fails++;
      end
      if (got.saturated !== e.fl.saturated) begin
        $error("saturated: expected %b, got %b", e.fl.saturated, got.saturated);
        fails++;
      end
    endfunction
  endclass

  logic          clk = 0;
  logic          rst_n = 0;
  logic          cfg_wr_en = 0;
  logic [30:0]   cfg_wr_data = '0;
  logic          in_tvalid = 0;
  logic          in_tready;
  logic [127:0]  in_tdata = '0;   // a_re, a_im, b_re, b_im from the lowest bit up
  logic [3:0]    in_tuser = '0;   // op
  logic          out_tvalid;
  logic          out_tready = 0;
  logic [63:0]   out_tdata;       // res_re, res_im from the lowest bit up
  logic [4:0]    out_tuser;       // is_equal, is_greater, is_greater_equal, div_error, saturated

  alu_scoreboard results = new();
  int            stall_left = 0;

  complex_fixed_point_alu_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #4 clk = ~clk;

  // Mostly no gap, often a short one, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Operand mix: extremes, zero, small values near the thresholds, full range
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3: return 32'($signed($urandom_range(0, 8)) - 4);
      4: return 32'($signed($urandom_range(0, 32'h0006_0000)) - 32'sh0003_0000);
      default: return $urandom();
    endcase
  endfunction

  // Drive the result side's ready with random stalls
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 0;
    end else if ($urandom_range(0, 3) == 0) begin
      stall_left <= pick_gap();
      out_tready <= 0;
    end else begin
      out_tready <= 1;
    end
  end

  // Check every accepted result item
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) results.check(out_tdata, out_tuser);
  end

  // Present one item, hold it until accepted, then note it for prediction
  task automatic send_item(logic [3:0] op, logic [31:0] ar, logic [31:0] ai,
                           logic [31:0] br, logic [31:0] bi);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_tvalid <= 0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1;
    in_tuser <= op;
    in_tdata <= {bi, br, ai, ar};
    do @(posedge clk); while (!in_tready);
    results.note(op, {bi, br, ai, ar});
  endtask

  // Drain the pipe, then write the threshold while nothing is in flight
  task automatic write_eps(logic [30:0] value);
    @(negedge clk);
    in_tvalid <= 0;
    while (results.pending.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_wr_en <= 1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 0;
    results.eps = value;
  endtask

  task automatic run_random(int count);
    logic [3:0] op;
    repeat (count) begin
      // keep undefined opcodes rare
      op = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(10, 15))
                                        : 4'($urandom_range(0, 9));
      send_item(op, pick_value(), pick_value(), pick_value(), pick_value());
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;

    // directed: every opcode at the extremes
    for (int op = 0; op < 16; op++) begin
      send_item(4'(op), 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
    end
    send_item(OP_DIV, 32'h0001_0000, 32'h0001_0000, 32'h0, 32'h0);   // zero divisor
    send_item(OP_DIV, 32'h0001_0000, 32'h0, 32'h0000_0001, 32'h0);   // |b|^2 below eps
    send_item(OP_DIV, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0100, 32'h0);  // saturates
    send_item(OP_SDIV, 32'h0001_0000, 32'h0002_0000, 32'h0, 32'h1234);      // scalar by zero
    send_item(OP_SDIV, 32'h0003_0000, 32'hFFFD_0000, 32'hFFFF_0000, 32'h0); // negative scalar
    send_item(OP_CONJ, 32'h1234_5678, 32'h0000_0000, 32'h0, 32'h0);  // im below eps
    send_item(OP_CONJ, 32'h1234_5678, 32'h8000_0000, 32'h0, 32'h0);  // negate saturates
    send_item(OP_CMP, 32'h0001_0000, 32'hFFFF_0000, 32'h0001_0000, 32'hFFFF_0000);
    send_item(OP_SCMP, 32'h0001_0000, 32'h0, 32'hFFFF_FFFF, 32'h0);  // negative scalar
    send_item(OP_SCMP, 32'h0003_0000, 32'h0004_0000, 32'h0005_0000, 32'h0);

    write_eps(EPS_RESET);
    run_random(PHASE_ITEMS);
    write_eps(31'd0);
    run_random(PHASE_ITEMS);
    write_eps(31'h7FFF_FFFF);
    run_random(PHASE_ITEMS);
    write_eps(31'h0001_0000);
    run_random(PHASE_ITEMS);
    write_eps(31'($urandom()));
    run_random(PHASE_ITEMS);

    // drain, then leave room for anything unexpected to show up
    @(negedge clk);
    in_tvalid <= 0;
    while (results.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (results.fails == 0 && results.pending.size() == 0) begin
      $display("tb_complex_fixed_point_alu_core: PASS");
    end else begin
      $display("tb_complex_fixed_point_alu_core: FAIL");
    end
    $finish;
  end

  // Hold a hard limit on the run
  initial begin
    #20ms;
    $display("tb_complex_fixed_point_alu_core: FAIL");
    $finish;
  end

endmodule
